### rtl/xrng_pkg.sv
// Package for the xoshiro256** draw block: constants, request codes and
// the controller/datapath command and status types. Depends on nothing.
package xrng_pkg;

    localparam logic [63:0] SeedReset  = 64'hdeadbeefcafe1234;
    localparam logic [63:0] GoldenStep = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MixMulA    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MixMulB    = 64'h94d049bb133111eb;

    localparam logic [1:0] FUNC_RAW     = 2'd0;
    localparam logic [1:0] FUNC_BOUNDED = 2'd1;
    localparam logic [1:0] FUNC_BYTES   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    // Datapath commands, one per cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SEED_LOAD,   // acc <= seed
        CMD_MIX_ADD,     // acc += golden, z <= acc+golden ^ >>30
        CMD_MIX_MUL_A,   // z <= z * A (partial products)
        CMD_MIX_XOR_B,   // z <= z ^ z>>27
        CMD_MIX_MUL_B,   // z <= z * B
        CMD_MIX_STORE,   // shift z ^ z>>31 into state
        CMD_GEN_STEP,    // compute output, advance state
        CMD_DIV_INIT,    // start remainder
        CMD_DIV_STEP,    // one remainder bit
        CMD_PROD,        // product of draw and bound
        CMD_MUL_STEP     // one 16-bit partial product of a 64-bit multiply
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic       mul_sel_b;
    } t_ctl;

    typedef struct packed {
        logic        accept;    // product low half meets threshold
        logic [63:0] word;      // last generator output
        logic [31:0] prod_hi;   // high half of draw * bound
    } t_sts;

endpackage

### rtl/xrng_datapath.sv
// Datapath of the xoshiro256** draw block: state words, splitmix64
// expansion, remainder unit and bounded-draw product. Uses xrng_pkg.
module xrng_datapath (
    input  logic                  i_clk,
    input  logic [63:0]           i_seed,
    input  logic [31:0]           i_bound,
    input  xrng_pkg::t_ctl        i_ctl,
    input  logic [1:0]            i_mul_idx,
    output xrng_pkg::t_sts        o_sts
);
    logic [63:0] r_s0, r_s1, r_s2, r_s3;
    logic [63:0] r_acc, r_z, r_mz, r_word;
    logic [31:0] r_rem, r_thr, r_num, r_phi, r_plo;
    logic [63:0] n_acc, mcand, mpart;
    logic [63:0] s3_mix;
    logic [32:0] trial;

    assign n_acc = r_acc + xrng_pkg::GoldenStep;
    assign mcand = i_ctl.mul_sel_b ? xrng_pkg::MixMulB : xrng_pkg::MixMulA;
    // 64 x 16 partial product, low 64 bits only, shifted into place.
    assign mpart = (r_z * mcand[16*i_mul_idx +: 16]) << (16 * i_mul_idx);
    // Restoring remainder step over (2^32 - bound).
    assign trial = {r_rem, r_num[31]} - {1'b0, i_bound};
    // Last state word before its rotation by 45.
    assign s3_mix = r_s3 ^ r_s1;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            xrng_pkg::CMD_SEED_LOAD: r_acc <= i_seed;
            xrng_pkg::CMD_MIX_ADD: begin
                r_acc <= n_acc;
                r_z   <= n_acc ^ (n_acc >> 30);
                r_mz  <= '0;
            end
            xrng_pkg::CMD_MUL_STEP:  r_mz <= r_mz + mpart;
            xrng_pkg::CMD_MIX_XOR_B: begin
                r_z  <= r_mz ^ (r_mz >> 27);
                r_mz <= '0;
            end
            xrng_pkg::CMD_MIX_STORE: begin
                r_s0 <= r_s1;
                r_s1 <= r_s2;
                r_s2 <= r_s3;
                r_s3 <= r_mz ^ (r_mz >> 31);
            end
            xrng_pkg::CMD_GEN_STEP: begin
                r_word <= ({(r_s1 * 64'd5)} << 7 | (r_s1 * 64'd5) >> 57) * 64'd9;
                r_s0 <= r_s0 ^ r_s3 ^ r_s1;
                r_s1 <= r_s1 ^ r_s2 ^ r_s0;
                r_s2 <= r_s2 ^ r_s0 ^ (r_s1 << 17);
                r_s3 <= {s3_mix[18:0], s3_mix[63:19]};
            end
            xrng_pkg::CMD_DIV_INIT: begin
                r_rem <= '0;
                r_num <= 32'd0 - i_bound;
            end
            xrng_pkg::CMD_DIV_STEP: begin
                r_rem <= trial[32] ? {r_rem[30:0], r_num[31]} : trial[31:0];
                r_num <= {r_num[30:0], 1'b0};
            end
            xrng_pkg::CMD_PROD: begin
                r_thr <= r_rem;
                {r_phi, r_plo} <= r_word[63:32] * i_bound;
            end
            default: ;
        endcase
    end

    assign o_sts.accept  = r_plo >= r_thr;
    assign o_sts.word    = r_word;
    assign o_sts.prod_hi = r_phi;
endmodule

### rtl/xrng_ctrl.sv
// Controller of the xoshiro256** draw block: seeding sequence, request
// handling and result register. Uses xrng_pkg.
module xrng_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_seed_we,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_func,
    input  logic [31:0]           i_upper_bound,
    input  logic [3:0]            i_byte_count,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [63:0]           o_value,
    output logic [3:0]            o_valid_bytes,
    output xrng_pkg::t_ctl        o_ctl,
    output logic [1:0]            o_mul_idx,
    input  xrng_pkg::t_sts        i_sts
);
    typedef enum logic [3:0] {
        S_SEED, S_MADD, S_MULA, S_XORB, S_MULB, S_STORE,
        S_IDLE, S_GEN, S_DINIT, S_DIV, S_PROD, S_CHECK, S_DONE
    } t_state;

    t_state      r_state;
    logic [1:0]  r_word_cnt, r_mul_idx;
    logic [4:0]  r_div_cnt;
    logic [1:0]  r_func;
    logic [3:0]  r_count;
    logic        r_out_valid;
    logic [63:0] r_value;
    logic [3:0]  r_vbytes;
    logic [3:0]  sat_count;
    logic        in_accept;

    // A seed write in the same cycle holds off any request.
    assign o_stall       = (r_state != S_IDLE) || i_seed_we || (r_out_valid && i_stall);
    assign in_accept     = i_valid && !o_stall;
    assign o_valid       = r_out_valid;
    assign o_value       = r_value;
    assign o_valid_bytes = r_vbytes;
    assign o_mul_idx     = r_mul_idx;
    assign sat_count     = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;

    always_comb begin
        o_ctl.cmd       = xrng_pkg::CMD_NONE;
        o_ctl.mul_sel_b = (r_state == S_MULB);
        case (r_state)
            S_SEED:  o_ctl.cmd = xrng_pkg::CMD_SEED_LOAD;
            S_MADD:  o_ctl.cmd = xrng_pkg::CMD_MIX_ADD;
            S_MULA:  o_ctl.cmd = xrng_pkg::CMD_MUL_STEP;
            S_XORB:  o_ctl.cmd = xrng_pkg::CMD_MIX_XOR_B;
            S_MULB:  o_ctl.cmd = xrng_pkg::CMD_MUL_STEP;
            S_STORE: o_ctl.cmd = xrng_pkg::CMD_MIX_STORE;
            S_GEN:   o_ctl.cmd = xrng_pkg::CMD_GEN_STEP;
            S_DINIT: o_ctl.cmd = xrng_pkg::CMD_DIV_INIT;
            S_DIV:   o_ctl.cmd = xrng_pkg::CMD_DIV_STEP;
            S_PROD:  o_ctl.cmd = xrng_pkg::CMD_PROD;
            default: o_ctl.cmd = xrng_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SEED;
            r_out_valid <= 1'b0;
            r_word_cnt  <= '0;
            r_mul_idx   <= '0;
            r_div_cnt   <= '0;
            r_func      <= '0;
            r_count     <= '0;
        end else begin
            // An accepted request sets the result flag itself below.
            if (r_out_valid && !i_stall && !in_accept) begin
                r_out_valid <= 1'b0;
            end
            if (i_seed_we) begin
                r_state <= S_SEED;
            end else begin
                case (r_state)
                    S_SEED: begin
                        r_word_cnt <= '0;
                        r_state    <= S_MADD;
                    end
                    S_MADD: begin
                        r_mul_idx <= '0;
                        r_state   <= S_MULA;
                    end
                    S_MULA: begin
                        r_mul_idx <= r_mul_idx + 2'd1;
                        if (r_mul_idx == 2'd3) begin
                            r_state <= S_XORB;
                        end
                    end
                    S_XORB: begin
                        r_mul_idx <= '0;
                        r_state   <= S_MULB;
                    end
                    S_MULB: begin
                        r_mul_idx <= r_mul_idx + 2'd1;
                        if (r_mul_idx == 2'd3) begin
                            r_state <= S_STORE;
                        end
                    end
                    S_STORE: begin
                        r_word_cnt <= r_word_cnt + 2'd1;
                        r_state    <= (r_word_cnt == 2'd3) ? S_IDLE : S_MADD;
                    end
                    S_IDLE: begin
                        if (in_accept) begin
                            r_func  <= i_func;
                            r_count <= sat_count;
                            if (i_func == xrng_pkg::FUNC_RAW ||
                                (i_func == xrng_pkg::FUNC_BYTES &&
                                 i_byte_count != 4'd0)) begin
                                r_out_valid <= 1'b0;
                                r_state     <= S_GEN;
                            end else if (i_func == xrng_pkg::FUNC_BOUNDED &&
                                         i_upper_bound > 32'd1) begin
                                r_out_valid <= 1'b0;
                                r_state     <= S_DINIT;
                            end else begin
                                r_value     <= '0;
                                r_vbytes    <= (i_func == xrng_pkg::FUNC_BOUNDED) ?
                                               4'd4 : 4'd0;
                                r_out_valid <= 1'b1;
                            end
                        end
                    end
                    S_DINIT: begin
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                    S_DIV: begin
                        r_div_cnt <= r_div_cnt + 5'd1;
                        if (r_div_cnt == 5'd31) begin
                            r_state <= S_GEN;
                        end
                    end
                    S_GEN: begin
                        r_state <= (r_func == xrng_pkg::FUNC_BOUNDED) ? S_PROD : S_DONE;
                    end
                    S_PROD:  r_state <= S_CHECK;
                    S_CHECK: begin
                        if (i_sts.accept) begin
                            r_value     <= {32'd0, i_sts.prod_hi};
                            r_vbytes    <= 4'd4;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_GEN;
                        end
                    end
                    S_DONE: begin
                        if (r_func == xrng_pkg::FUNC_RAW) begin
                            r_value  <= {32'd0, i_sts.word[63:32]};
                            r_vbytes <= 4'd4;
                        end else begin
                            r_value  <= i_sts.word;
                            r_vbytes <= r_count;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

### rtl/xoshiro256ss_rng_with_bounded_draw_core.sv
// Top level of the xoshiro256** draw block. Instantiates the controller
// and the datapath; uses xrng_pkg.
//
// One request in, one result out. A raw or byte draw passes through the
// generate and done states between acceptance and result; a bounded draw
// first forms the rejection threshold with a bit-serial remainder (one setup
// step and 32 bit steps), then tries draws through the generate, product and
// check states until one is accepted. Requests that need no draw (bound 0 or
// 1, byte count 0, unused kind) have their result registered at acceptance.
// After reset, and after each seed write, the block expands the seed through
// four splitmix64 steps (each multiply is four 16-bit partial products on one
// shared multiplier) and accepts no transaction meanwhile; no transaction is
// taken in the cycle of a seed write either. A new request is taken only once
// the previous result has left or is leaving the output register.
module xoshiro256ss_rng_with_bounded_draw_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed_value,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_upper_bound,
    input  logic [3:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value,
    output logic [3:0]  o_valid_bytes
);
    // The seed register itself; the reset value is expanded after reset.
    logic [63:0]     r_seed;
    // Bound held for the whole bounded draw.
    logic [31:0]     r_bound;
    xrng_pkg::t_ctl  ctl;
    xrng_pkg::t_sts  sts;
    logic [1:0]      mul_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= xrng_pkg::SeedReset;
        end else if (i_seed_we) begin
            r_seed <= i_seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_bound <= i_upper_bound;
        end
    end

    xrng_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_seed_we, .i_valid, .o_stall, .i_func,
        .i_upper_bound, .i_byte_count, .o_valid, .i_stall, .o_value,
        .o_valid_bytes, .o_ctl(ctl), .o_mul_idx(mul_idx), .i_sts(sts)
    );

    xrng_datapath u_dp (
        .i_clk, .i_seed(r_seed), .i_bound(r_bound),
        .i_ctl(ctl), .i_mul_idx(mul_idx), .o_sts(sts)
    );
endmodule

### rtl/xrng_checker.sv
// Port-level checker for the xoshiro256** draw block, bound to the top
// level. Uses no package.
module xrng_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_value,
    input logic [3:0]  o_valid_bytes
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value)) else $error("result dropped");
    a_vb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_valid_bytes <= 4'd8) else $error("valid_bytes out of range");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_bytes == 4'd0 |-> o_value == 64'd0)
        else $error("empty result carries data");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_stall)
        else $error("not quiet after reset");
endmodule

bind xoshiro256ss_rng_with_bounded_draw_core xrng_checker u_chk (.*);

### test/tb.sv
// Self-checking testbench for xoshiro256ss_rng_with_bounded_draw_core.
// It predicts every result with its own xoshiro256**/splitmix64 model and
// depends only on the RTL and on xrng_pkg for constants and request codes.
module tb;

    // Every request gives exactly one result. The result is checked against
    // the prediction that was made when the request transaction was accepted.
    typedef struct {
        logic [63:0] value;
        logic [3:0]  nbytes;
    } t_draw;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_seed_we;
    logic [63:0] i_seed_value;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_func;
    logic [31:0] i_upper_bound;
    logic [3:0]  i_byte_count;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_value;
    logic [3:0]  o_valid_bytes;

    xoshiro256ss_rng_with_bounded_draw_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_value  (i_seed_value),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_upper_bound (i_upper_bound),
        .i_byte_count  (i_byte_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_valid_bytes (o_valid_bytes)
    );

    // Settle time: the longest bounded draw seen in practice plus a seed
    // expansion, used before seed writes and at the end of the run.
    localparam int SettleCycles = 120;
    localparam int WatchdogLimit = 20000;
    localparam int HoldOffCycles = 300;

    // The predicted generator state is kept here, apart from the block.
    logic [63:0] gen_state [4];
    t_draw       pending_draws [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_reqs = 0;
    int          hold_off_taken = 0;
    int          hold_off_left = 0;
    int          quiet_cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // One splitmix64 step on the running accumulator.
    function automatic logic [63:0] splitmix(inout logic [63:0] acc);
        logic [63:0] z;
        acc = acc + xrng_pkg::GoldenStep;
        z = acc;
        z = (z ^ (z >> 30)) * xrng_pkg::MixMulA;
        z = (z ^ (z >> 27)) * xrng_pkg::MixMulB;
        return z ^ (z >> 31);
    endfunction

    task automatic expand_seed(input logic [63:0] seed);
        logic [63:0] acc;
        acc = seed;
        for (int k = 0; k < 4; k++) begin
            gen_state[k] = splitmix(acc);
        end
    endtask

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

    // Produces one xoshiro256** output word and advances the state.
    task automatic advance_generator(output logic [63:0] word);
        logic [63:0] shifted;
        word = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
        shifted = gen_state[1] << 17;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= shifted;
        gen_state[3] = rotl64(gen_state[3], 45);
    endtask

    // Multiply-and-reject draw below the bound. Bounds of 0 and 1 answer 0
    // and leave the generator alone.
    task automatic draw_below(input logic [31:0] bound, output logic [31:0] answer);
        logic [31:0] threshold;
        logic [63:0] word;
        logic [63:0] product;
        answer = '0;
        if (bound > 32'd1) begin
            threshold = (32'd0 - bound) % bound;
            forever begin
                advance_generator(word);
                product = {32'd0, word[63:32]} * {32'd0, bound};
                if (product[31:0] >= threshold) begin
                    answer = product[63:32];
                    break;
                end
            end
        end
    endtask

    task automatic predict_draw(input logic [1:0] func, input logic [31:0] bound,
                                input logic [3:0] count);
        t_draw       d;
        logic [63:0] word;
        logic [31:0] answer;
        d.value = '0;
        d.nbytes = '0;
        case (func)
            xrng_pkg::FUNC_RAW: begin
                advance_generator(word);
                d.value = {32'd0, word[63:32]};
                d.nbytes = 4'd4;
            end
            xrng_pkg::FUNC_BOUNDED: begin
                draw_below(bound, answer);
                d.value = {32'd0, answer};
                d.nbytes = 4'd4;
            end
            xrng_pkg::FUNC_BYTES: begin
                // A zero count draws nothing; counts above eight saturate.
                if (count != 4'd0) begin
                    advance_generator(word);
                    d.value = word;
                    d.nbytes = (count > 4'd8) ? 4'd8 : count;
                end
            end
            default: ;
        endcase
        pending_draws.push_back(d);
    endtask

    // Sends one request transaction. Inputs change only at the falling edge;
    // the request is predicted at the rising edge where it is accepted.
    task automatic send_request(input logic [1:0] func, input logic [31:0] bound,
                                input logic [3:0] count);
        @(negedge i_clk);
        while (($urandom % 100) < send_idle_pct) begin
            i_valid = 1'b0;
            i_func = 2'($urandom);
            i_upper_bound = $urandom;
            i_byte_count = 4'($urandom);
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func = func;
        i_upper_bound = bound;
        i_byte_count = count;
        forever begin
            @(posedge i_clk);
            if (!o_stall) begin
                break;
            end
        end
        predict_draw(func, bound, count);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_draws.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // The seed is written only while the block is idle; the model reloads
    // its state at the same moment.
    task automatic write_seed(input logic [63:0] seed);
        wait_drained();
        i_seed_we = 1'b1;
        i_seed_value = seed;
        @(negedge i_clk);
        i_seed_we = 1'b0;
        i_seed_value = 64'($urandom) << 32 | 64'($urandom);
        expand_seed(seed);
    endtask

    task automatic set_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Random request with most weight on the ordinary cases.
    task automatic send_random_request();
        logic [1:0]  func;
        logic [31:0] bound;
        logic [3:0]  count;
        int          pick;
        pick = $urandom_range(0, 99);
        func = (pick < 30) ? xrng_pkg::FUNC_RAW : (pick < 65) ? xrng_pkg::FUNC_BOUNDED :
               (pick < 95) ? xrng_pkg::FUNC_BYTES : xrng_pkg::FUNC_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            bound = $urandom_range(0, 3);
        end else if (pick < 5) begin
            bound = $urandom_range(2, 1000);
        end else if (pick < 7) begin
            bound = 32'h8000_0000 + $urandom_range(0, 255);
        end else begin
            bound = $urandom;
        end
        count = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom);
        send_request(func, bound, count);
    endtask

    // Extremes of every field, every request kind and every special case.
    task automatic test_directed();
        set_phase(0, 0);
        send_request(xrng_pkg::FUNC_RAW, 32'h0, 4'h0);
        send_request(xrng_pkg::FUNC_RAW, 32'hffff_ffff, 4'hf);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'd0, 4'd4);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'd1, 4'd4);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'd2, 4'd4);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'd3, 4'd4);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'hffff_ffff, 4'd0);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'h8000_0000, 4'd0);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'h8000_0001, 4'd0);
        send_request(xrng_pkg::FUNC_BOUNDED, 32'h5555_5555, 4'd0);
        send_request(xrng_pkg::FUNC_BYTES, 32'd0, 4'd0);
        send_request(xrng_pkg::FUNC_BYTES, 32'd0, 4'd1);
        send_request(xrng_pkg::FUNC_BYTES, 32'd0, 4'd7);
        send_request(xrng_pkg::FUNC_BYTES, 32'd0, 4'd8);
        send_request(xrng_pkg::FUNC_BYTES, 32'd0, 4'd9);
        send_request(xrng_pkg::FUNC_BYTES, 32'hffff_ffff, 4'd15);
        send_request(xrng_pkg::FUNC_UNUSED, 32'hffff_ffff, 4'd15);
        send_request(xrng_pkg::FUNC_UNUSED, 32'd0, 4'd0);
    endtask

    // Random requests through every idling phase.
    task automatic test_random_phases();
        set_phase(0, 0);
        repeat (150) send_random_request();
        set_phase(58, 0);
        repeat (130) send_random_request();
        set_phase(0, 58);
        repeat (130) send_random_request();
        set_phase(7, 7);
        repeat (130) send_random_request();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_backpressure();
        set_phase(0, 0);
        hold_off_reqs = hold_off_reqs + 1;
        repeat (20) send_random_request();
    endtask

    // Seed writes, extremes included, each followed by a burst of draws.
    task automatic test_seed_reload();
        write_seed(64'h0);
        repeat (25) send_random_request();
        write_seed(64'hffff_ffff_ffff_ffff);
        set_phase(7, 7);
        repeat (25) send_random_request();
        write_seed({$urandom, $urandom});
        set_phase(58, 58);
        repeat (25) send_random_request();
        write_seed(xrng_pkg::SeedReset);
        set_phase(0, 0);
        repeat (25) send_random_request();
    endtask

    // Receiver side: random stalls per phase, or a counted hold-off.
    always @(negedge i_clk) begin
        if (hold_off_taken != hold_off_reqs) begin
            hold_off_taken = hold_off_reqs;
            hold_off_left = HoldOffCycles;
        end
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else if (hold_off_left > 0) begin
            i_stall = 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_stall = (($urandom % 100) < recv_stall_pct);
        end
    end

    // Result checker: each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                $display("%0t: unexpected result value %h valid_bytes %0d",
                         $time, o_value, o_valid_bytes);
                mismatches++;
            end else begin
                want = pending_draws.pop_front();
                if (o_value !== want.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, o_value);
                    mismatches++;
                end
                if (o_valid_bytes !== want.nbytes) begin
                    $display("%0t: valid_bytes expected %0d actual %0d",
                             $time, want.nbytes, o_valid_bytes);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_seed_we = 1'b0;
        i_seed_value = '0;
        i_valid = 1'b0;
        i_func = '0;
        i_upper_bound = '0;
        i_byte_count = '0;
        expand_seed(xrng_pkg::SeedReset);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phases();
        test_backpressure();
        test_seed_reload();
        wait_drained();

        if (mismatches == 0 && pending_draws.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
